// ===== sv/tachometer_pulse_window_smoother_top_defines.svh =====
// ----------------------------------------------------------------------------
// tachometer pulse window smoother - assertion macros
// Shared assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TACHOMETER_PULSE_WINDOW_SMOOTHER_TOP_DEFINES_SVH
`define TACHOMETER_PULSE_WINDOW_SMOOTHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define TPWS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("tpws assertion failed");
// checked during reset as well
`define TPWS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("tpws assertion failed");
`else
`define TPWS_ASSERT(lbl, prop)
`define TPWS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== sv/tpws_pkg.sv =====
// ----------------------------------------------------------------------------
// tpws_pkg
// Types and constants shared by the tachometer smoother modules.
// ----------------------------------------------------------------------------
package tpws_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 20;
    localparam int PROD_W = 2 * MUL_W;

    // divide by ten as multiply by reciprocal, exact for operands below 2**22
    localparam int              RECIP_SHIFT = 23;
    localparam logic [MUL_W-1:0] RECIP_TEN  = 20'd838861;

    // configuration register indexes
    localparam logic [7:0] CFG_LOCKOUT  = 8'd0;
    localparam logic [7:0] CFG_WINDOW   = 8'd1;
    localparam logic [7:0] CFG_RPP      = 8'd2;
    localparam logic [7:0] CFG_ZERO_WIN = 8'd3;

    // operation codes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RAW   = 6'b000010,
        S_BLEND = 6'b000100,
        S_QUOT  = 6'b001000,
        S_SHOW  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    // request to the shared multiplier
    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

endpackage

// ===== sv/tachometer_pulse_window_smoother_top.sv =====
// ----------------------------------------------------------------------------
// tachometer_pulse_window_smoother_top
// Pulse-counting tachometer with lockout, windowed rpm and smoothing.
// ----------------------------------------------------------------------------
// An edge item and a tick item that does not close the window leave the
// sequencer idle, ready for the next item. A tick that closes the window
// holds off the next item while the sequencer steps through accept, raw
// multiply, blend, floor to tens and emit, with a divide by ten after the
// blend when the new reading is blended with a nonzero smoothed value, and
// while it waits for the output register to empty; the one shared multiplier
// is used twice per closed window, or three times when blending.
// Input tuser carries the operation (0 edge, 1 tick).
`include "tachometer_pulse_window_smoother_top_defines.svh"

module tachometer_pulse_window_smoother_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] timestamp_us
    input  logic        i_s_axis_tuser,   // [0] operation
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [15:0] rpm_shown, [31:16] rpm_smoothed,
                                          // [39:32] window_pulses
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import tpws_pkg::*;

    // configuration registers
    logic [15:0] r_lockout;
    logic [15:0] r_window;
    logic [9:0]  r_rpp;
    logic [3:0]  r_zero_win;

    // measurement state
    logic [31:0] r_last_edge, n_last_edge;
    logic [7:0]  r_pulses, n_pulses;
    logic [15:0] r_ticks, n_ticks;
    logic [15:0] r_smoothed, n_smoothed;
    logic [3:0]  r_run, n_run;
    logic [7:0]  r_win_pulses, n_win_pulses;
    t_state      r_state, n_state;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [39:0] r_out_data, n_out_data;

    // shared multiplier
    t_mul_req          mul_req;
    logic [PROD_W-1:0] mul_prod;

    tpws_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    logic        in_acc;
    logic        out_free;
    logic [31:0] gap;
    logic [15:0] ticks_inc;
    logic [15:0] raw;
    logic [3:0]  run_inc;
    logic [19:0] blend_sum;
    logic [15:0] quot;
    logic [15:0] shown;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // datapath helpers
    assign gap       = i_s_axis_tdata - r_last_edge;
    assign ticks_inc = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;
    assign raw       = (|mul_prod[17:16]) ? 16'hFFFF : mul_prod[15:0];
    assign run_inc   = (r_run == 4'hF) ? r_run : r_run + 4'd1;
    assign blend_sum = {3'b000, raw, 1'b0} + {4'b0000, raw}
                     + {1'b0, r_smoothed, 3'b000} - {4'b0000, r_smoothed};
    assign quot      = mul_prod[RECIP_SHIFT+15:RECIP_SHIFT];
    assign shown     = {quot[12:0], 3'b000} + {quot[14:0], 1'b0};

    // sequencer and state update
    always_comb begin
        n_state      = r_state;
        n_last_edge  = r_last_edge;
        n_pulses     = r_pulses;
        n_ticks      = r_ticks;
        n_smoothed   = r_smoothed;
        n_run        = r_run;
        n_win_pulses = r_win_pulses;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        mul_req      = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_s_axis_tuser == OP_EDGE) begin
                        if (gap > {16'h0000, r_lockout}) begin
                            n_last_edge = i_s_axis_tdata;
                            if (r_pulses != 8'hFF) n_pulses = r_pulses + 8'd1;
                        end
                    end else if (ticks_inc >= r_window) begin
                        n_win_pulses = r_pulses;
                        n_pulses     = '0;
                        n_ticks      = '0;
                        n_state      = S_RAW;
                    end else begin
                        n_ticks = ticks_inc;
                    end
                end
            end
            S_RAW: begin
                mul_req.en = 1'b1;
                mul_req.a  = {12'h000, r_win_pulses};
                mul_req.b  = {10'h000, r_rpp};
                n_state    = S_BLEND;
            end
            S_BLEND: begin
                n_state = S_SHOW;
                if (r_smoothed == 16'h0000) begin
                    n_smoothed = raw;
                    n_run      = '0;
                end else if (raw == 16'h0000) begin
                    if (run_inc >= r_zero_win) begin
                        n_smoothed = '0;
                        n_run      = '0;
                    end else begin
                        n_run = run_inc;
                    end
                end else begin
                    n_run      = '0;
                    mul_req.en = 1'b1;
                    mul_req.a  = blend_sum;
                    mul_req.b  = RECIP_TEN;
                    n_state    = S_QUOT;
                end
            end
            S_QUOT: begin
                n_smoothed = quot;
                n_state    = S_SHOW;
            end
            S_SHOW: begin
                mul_req.en = 1'b1;
                mul_req.a  = {4'h0, r_smoothed};
                mul_req.b  = RECIP_TEN;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_win_pulses, r_smoothed, shown};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and measurement registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_edge <= '0;
            r_pulses    <= '0;
            r_ticks     <= '0;
            r_smoothed  <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_edge <= n_last_edge;
            r_pulses    <= n_pulses;
            r_ticks     <= n_ticks;
            r_smoothed  <= n_smoothed;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_win_pulses <= n_win_pulses;
        r_out_data   <= n_out_data;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout  <= 16'd5000;
            r_window   <= 16'd500;
            r_rpp      <= 10'd360;
            r_zero_win <= 4'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LOCKOUT:  r_lockout  <= i_cfg_data;
                CFG_WINDOW:   r_window   <= i_cfg_data;
                CFG_RPP:      r_rpp      <= i_cfg_data[9:0];
                CFG_ZERO_WIN: r_zero_win <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // checks
    `TPWS_ASSERT(a_emit_loads, (r_state == S_EMIT) && out_free |=> o_m_axis_tvalid)
    `TPWS_ASSERT(a_close_clears, in_acc && (i_s_axis_tuser == OP_TICK)
        && (ticks_inc >= r_window) |=> (r_ticks == 16'h0000) && (r_pulses == 8'h00))
    `TPWS_ASSERT(a_smooth_idle, (r_state == S_IDLE) |=> $stable(r_smoothed))
    `TPWS_ASSERT(a_shown_floor, o_m_axis_tvalid |-> (o_m_axis_tdata[15:0]
        <= o_m_axis_tdata[31:16]) && (o_m_axis_tdata[31:16] - o_m_axis_tdata[15:0] < 16'd10))
    `TPWS_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> (r_state == S_IDLE) && !o_m_axis_tvalid)

endmodule

// ===== sv/tpws_mul.sv =====
// ----------------------------------------------------------------------------
// tpws_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module tpws_mul (
    input  logic                      i_clk,
    input  tpws_pkg::t_mul_req        i_req,
    output logic [tpws_pkg::PROD_W-1:0] o_prod
);
    import tpws_pkg::*;

    logic [PROD_W-1:0] r_prod;

    // product register, loaded on request
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// tachometer pulse window smoother - testbench
// Drives edge and tick items under several register settings and idle
// patterns, predicts each closed-window reading and checks it field by field.
// ----------------------------------------------------------------------------

// one reading as it travels on the result bus, lowest field last
typedef struct packed {
    logic [7:0]  pulses;
    logic [15:0] smoothed;
    logic [15:0] shown;
} t_rpm_reading;

// tracks lockout, window tallies and smoothing, holds the readings still due
class rpm_tracker;
    bit [15:0] lockout_us;
    bit [15:0] window_ms;
    bit [9:0]  rpm_per_pulse;
    bit [3:0]  zero_windows;
    bit [31:0] last_edge;
    bit [7:0]  pulse_count;
    bit [15:0] tick_count;
    bit [15:0] smoothed;
    bit [3:0]  empty_run;
    t_rpm_reading readings_due[$];
    int errors;
    int readings_seen;

    function new();
        lockout_us    = 16'd5000;
        window_ms     = 16'd500;
        rpm_per_pulse = 10'd360;
        zero_windows  = 4'd3;
        last_edge     = '0;
        pulse_count   = '0;
        tick_count    = '0;
        smoothed      = '0;
        empty_run     = '0;
        errors        = 0;
        readings_seen = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [15:0] val);
        case (idx)
            tpws_pkg::CFG_LOCKOUT:  lockout_us    = val;
            tpws_pkg::CFG_WINDOW:   window_ms     = val;
            tpws_pkg::CFG_RPP:      rpm_per_pulse = val[9:0];
            tpws_pkg::CFG_ZERO_WIN: zero_windows  = val[3:0];
            default: ;
        endcase
    endfunction

    // raw rpm, smoothing step and the reading it yields
    function void close_window();
        int unsigned  raw;
        int unsigned  blend;
        t_rpm_reading r;
        raw = int'(pulse_count) * int'(rpm_per_pulse);
        if (raw > 65535) raw = 65535;
        if (smoothed == 16'd0) begin
            smoothed  = 16'(raw);
            empty_run = '0;
        end else if (raw == 0) begin
            if (empty_run != 4'hF) empty_run++;
            if (empty_run >= zero_windows) begin
                smoothed  = '0;
                empty_run = '0;
            end
        end else begin
            empty_run = '0;
            blend = (3 * raw + 7 * int'(smoothed)) / 10;
            if (blend > 65535) blend = 65535;
            smoothed = 16'(blend);
        end
        r.pulses   = pulse_count;
        r.smoothed = smoothed;
        r.shown    = 16'((int'(smoothed) / 10) * 10);
        readings_due.push_back(r);
        pulse_count = '0;
        tick_count  = '0;
    endfunction

    // accepted input item
    function void note_item(logic op, logic [31:0] ts);
        bit [31:0] gap;
        if (op == tpws_pkg::OP_EDGE) begin
            gap = ts - last_edge;
            if (gap > {16'd0, lockout_us}) begin
                if (pulse_count != 8'hFF) pulse_count++;
                last_edge = ts;
            end
        end else begin
            if (tick_count != 16'hFFFF) tick_count++;
            if (tick_count >= window_ms) close_window();
        end
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // accepted result item against the oldest reading due
    task check_reading(logic [39:0] data);
        t_rpm_reading got;
        t_rpm_reading want;
        got = data;
        if (readings_due.size() == 0) begin
            report($sformatf("unexpected reading %h", data));
            return;
        end
        want = readings_due.pop_front();
        readings_seen++;
        if (got.shown != want.shown)
            report($sformatf("rpm_shown %0d, want %0d", got.shown, want.shown));
        if (got.smoothed != want.smoothed)
            report($sformatf("rpm_smoothed %0d, want %0d", got.smoothed, want.smoothed));
        if (got.pulses != want.pulses)
            report($sformatf("window_pulses %0d, want %0d", got.pulses, want.pulses));
    endtask

    function int pending();
        return readings_due.size();
    endfunction
endclass

module testbench;
    import tpws_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;   // [31:0] timestamp_us
    logic        i_s_axis_tuser  = 1'b0; // [0] operation
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;         // [15:0] rpm_shown, [31:16] rpm_smoothed,
                                         // [39:32] window_pulses
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index     = '0;
    logic [15:0] i_cfg_data      = '0;

    rpm_tracker tracker = new();

    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    int          cur_lockout     = 5000;
    int          cycle_count     = 0;
    logic        res_take        = 1'b0;
    logic [39:0] res_data        = '0;

    tachometer_pulse_window_smoother_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // sample the result bus mid-cycle, away from the driving edge
    always @(negedge i_clk) begin
        res_take = i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        res_data = o_m_axis_tdata;
    end

    // result side: check accepted items, stall at random
    always @(posedge i_clk) begin
        if (res_take) tracker.check_reading(res_data);
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // one input item, with random idle cycles in front
    task automatic send_item(input logic op, input logic [31:0] ts);
        logic rdy;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ts;
        i_s_axis_tuser  <= op;
        rdy = 1'b0;
        while (!rdy) begin
            @(negedge i_clk);
            rdy = o_s_axis_tready;
            @(posedge i_clk);
        end
        tracker.note_item(op, ts);
    endtask

    // one register write
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        logic rdy;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        rdy = 1'b0;
        while (!rdy) begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end
        tracker.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every reading due, then let the sequencer finish
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] lockout, input logic [15:0] window,
                             input logic [9:0] rpp, input logic [3:0] zw);
        settle();
        write_reg(CFG_LOCKOUT,  lockout);
        write_reg(CFG_WINDOW,   window);
        write_reg(CFG_RPP,      {6'd0, rpp});
        write_reg(CFG_ZERO_WIN, {12'd0, zw});
        cur_lockout = lockout;
    endtask

    // mostly rising edge times around the lockout, some ticks, some noise
    task automatic random_run(input int n);
        int          r;
        logic [31:0] now;
        now = $urandom();
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                send_item(OP_TICK, $urandom());
            end else if (r < 82) begin
                now = now + $urandom_range(0, 2 * cur_lockout + 2);
                send_item(OP_EDGE, now);
            end else if (r < 90) begin
                // edge stamped at or before the last rising time
                send_item(OP_EDGE, now - $urandom_range(0, cur_lockout + 1));
            end else begin
                send_item(OP_EDGE, $urandom());
            end
        end
    endtask

    // stimulus
    initial begin
        int          phase;
        int          rand_items;
        int          seen_at_start;
        int          r;
        logic [15:0] lockout;
        logic [15:0] window;
        logic [9:0]  rpp;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: first edge against time zero, lockout boundary, wrap
        send_item(OP_EDGE, 32'd0);
        send_item(OP_EDGE, 32'd5000);
        send_item(OP_EDGE, 32'd5001);
        send_item(OP_EDGE, 32'hFFFF_FFFF);
        send_item(OP_EDGE, 32'h0000_0FFF);

        // one-tick windows, longest empty-window limit, empty windows, lockout boundary
        configure(16'hFFFF, 16'd1, 10'd1023, 4'd15);
        repeat (17) send_item(OP_TICK, $urandom());
        send_item(OP_EDGE, 32'h0000_FFFE);
        send_item(OP_EDGE, 32'h0000_FFFF);
        send_item(OP_TICK, $urandom());
        send_item(OP_EDGE, 32'h0001_FFFF);
        send_item(OP_TICK, $urandom());

        // zero window length, zero multiplier, zero empty-window limit
        configure(16'd0, 16'd0, 10'd0, 4'd0);
        send_item(OP_EDGE, 32'h0002_0000);
        send_item(OP_TICK, $urandom());
        send_item(OP_TICK, $urandom());

        // pulse tally overflow and raw rpm saturation
        sender_idle_pct = 20;
        recv_stall_pct  = 20;
        configure(16'd0, 16'd1, 10'd1023, 4'd1);
        for (int k = 1; k <= 258; k++) send_item(OP_EDGE, k);
        send_item(OP_TICK, $urandom());
        for (int k = 1; k <= 70; k++) send_item(OP_EDGE, 1000 + k);
        send_item(OP_TICK, $urandom());
        send_item(OP_TICK, $urandom());

        // longest window left open, then shortened below the tally
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        configure(16'd0, 16'hFFFF, 10'd1, 4'd15);
        send_item(OP_EDGE, 32'h8000_0000);
        send_item(OP_EDGE, 32'h8000_0001);
        repeat (5) send_item(OP_TICK, $urandom());
        configure(16'd0, 16'd3, 10'd1, 4'd15);
        send_item(OP_TICK, $urandom());

        // random settings and idle patterns
        phase         = 0;
        rand_items    = 0;
        seen_at_start = tracker.readings_seen;
        while (rand_items < 128 || tracker.readings_seen - seen_at_start < 8) begin
            r = $urandom_range(0, 9);
            lockout = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 400));
            window  = ($urandom_range(0, 3) == 0) ? 16'd1 : 16'($urandom_range(1, 10));
            r = $urandom_range(0, 5);
            rpp = (r == 0) ? 10'd1023 : (r == 1) ? 10'd1 : 10'($urandom_range(1, 1023));
            configure(lockout, window, rpp, 4'($urandom_range(1, 15)));
            case (phase % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 83;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 83;
                end
                default: begin
                    sender_idle_pct = 20;
                    recv_stall_pct  = 20;
                end
            endcase
            random_run(32);
            rand_items += 32;
            phase++;
        end

        // drain and verdict
        settle();
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tpws_pkg.sv
sv/tpws_mul.sv
sv/tachometer_pulse_window_smoother_top.sv
tb/sv/testbench.sv
